// ----- rtl/fst_pkg.sv -----
`default_nettype none

package fst_pkg;

   localparam int NUM_BITS_DEF = 16;
   localparam int CHAR_W       = 8;
   localparam int FIELD_W      = 16;
   localparam int LEN_W        = 3;
   localparam int NUM_FLAGS    = 5;
   localparam int TDATA_W      = 56;

   localparam logic [CHAR_W-1:0] CH_NUL   = 8'd0;
   localparam logic [CHAR_W-1:0] CH_PCT   = 8'd37;
   localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_W-1:0] CH_H     = 8'h68;
   localparam logic [CHAR_W-1:0] CH_LOW_L = 8'h6C;
   localparam logic [CHAR_W-1:0] CH_UP_L  = 8'h4C;
   localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
   localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
   localparam logic [CHAR_W-1:0] CH_F     = 8'h66;
   localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
   localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
   localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
   localparam logic [CHAR_W-1:0] CH_P     = 8'h70;
   localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
   localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
   localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

   localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] LEN_HH   = 3'd1;
   localparam logic [LEN_W-1:0] LEN_H    = 3'd2;
   localparam logic [LEN_W-1:0] LEN_L    = 3'd3;
   localparam logic [LEN_W-1:0] LEN_LL   = 3'd4;
   localparam logic [LEN_W-1:0] LEN_BIG_L = 3'd5;

   localparam int FLAG_PLUS  = 0;
   localparam int FLAG_MINUS = 1;
   localparam int FLAG_ALT   = 2;
   localparam int FLAG_ZERO  = 3;
   localparam int FLAG_SPACE = 4;

   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_SPEC    = 1'b1;

   typedef struct packed {
      logic                 kind;
      logic [CHAR_W-1:0]    char_out;
      logic [NUM_FLAGS-1:0] flags;
      logic [FIELD_W-1:0]   min_width;
      logic                 has_precision;
      logic [FIELD_W-1:0]   precision;
      logic [LEN_W-1:0]     length_mod;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

`default_nettype wire

// ----- rtl/fst_core.sv -----
`default_nettype none

module fst_core
   import fst_pkg::*;
#(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [CHAR_W-1:0] req_tdata,
   input  wire logic              advance,
   output logic                   fire,
   output result_type             result
);

   localparam int ACC_W = NUM_BITS + 4;
   localparam logic [NUM_BITS-1:0] VAL_MAX = {NUM_BITS{1'b1}};

   logic                 s1_valid_ff, s1_valid_in;
   logic [CHAR_W-1:0]    s1_char_ff;
   logic                 in_spec_ff, in_spec_in;
   logic [NUM_FLAGS-1:0] flags_ff, flags_in;
   logic [NUM_BITS-1:0]  width_ff, width_in;
   logic                 width_run_ff, width_run_in;
   logic                 dot_ff, dot_in;
   logic [NUM_BITS-1:0]  prec_ff, prec_in;
   logic                 prec_run_ff, prec_run_in;
   logic [LEN_W-1:0]     len_ff, len_in;

   logic                 accept;
   logic                 digit;
   logic                 conv;
   logic [3:0]           dval;
   logic [NUM_BITS-1:0]  width_acc, prec_acc;

   function automatic logic [NUM_BITS-1:0] acc_digit(input logic [NUM_BITS-1:0] v,
                                                     input logic [3:0] d);
      logic [ACC_W-1:0] n;
      n = ACC_W'({v, 3'b000}) + ACC_W'({v, 1'b0}) + ACC_W'(d);
      acc_digit = (n[ACC_W-1:NUM_BITS] != '0) ? VAL_MAX : n[NUM_BITS-1:0];
   endfunction

   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;
   assign fire       = s1_valid_ff && advance;
   assign s1_valid_in = accept ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);

   assign digit = (s1_char_ff >= CH_ZERO) && (s1_char_ff <= CH_NINE);
   assign dval  = s1_char_ff[3:0];
   assign conv  = (s1_char_ff == CH_C) || (s1_char_ff == CH_D) || (s1_char_ff == CH_F) ||
                  (s1_char_ff == CH_I) || (s1_char_ff == CH_S) || (s1_char_ff == CH_O) ||
                  (s1_char_ff == CH_P) || (s1_char_ff == CH_U) || (s1_char_ff == CH_X) ||
                  (s1_char_ff == CH_UP_X);
   assign width_acc = acc_digit(width_ff, dval);
   assign prec_acc  = acc_digit(prec_ff, dval);

   always_comb begin
      in_spec_in   = in_spec_ff;
      flags_in     = flags_ff;
      width_in     = width_ff;
      width_run_in = width_run_ff;
      dot_in       = dot_ff;
      prec_in      = prec_ff;
      prec_run_in  = prec_run_ff;
      len_in       = len_ff;
      result       = '0;
      result.data.char_out = s1_char_ff;

      if (s1_char_ff == CH_NUL) begin
         in_spec_in   = 1'b0;
         flags_in     = '0;
         width_in     = '0;
         width_run_in = 1'b0;
         dot_in       = 1'b0;
         prec_in      = '0;
         prec_run_in  = 1'b0;
         len_in       = LEN_NONE;
      end else if (!in_spec_ff) begin
         if (s1_char_ff == CH_PCT) begin
            in_spec_in   = 1'b1;
            flags_in     = '0;
            width_in     = '0;
            width_run_in = 1'b0;
            dot_in       = 1'b0;
            prec_in      = '0;
            prec_run_in  = 1'b0;
            len_in       = LEN_NONE;
         end else begin
            result.valid = 1'b1;
         end
      end else begin
         width_run_in = 1'b0;
         prec_run_in  = 1'b0;
         if (s1_char_ff == CH_PLUS) begin
            flags_in[FLAG_PLUS] = 1'b1;
         end else if (s1_char_ff == CH_MINUS) begin
            flags_in[FLAG_MINUS] = 1'b1;
         end else if (s1_char_ff == CH_HASH) begin
            flags_in[FLAG_ALT] = 1'b1;
         end else if (s1_char_ff == CH_SPACE) begin
            flags_in[FLAG_SPACE] = 1'b1;
         end else if (digit) begin
            if (width_run_ff) begin
               width_in     = width_acc;
               width_run_in = 1'b1;
            end else if (prec_run_ff) begin
               prec_in     = prec_acc;
               prec_run_in = 1'b1;
            end else if (!dot_ff) begin
               if (width_ff == '0) begin
                  if (dval == 4'd0) begin
                     flags_in[FLAG_ZERO] = 1'b1;
                  end else begin
                     width_in     = NUM_BITS'(dval);
                     width_run_in = 1'b1;
                  end
               end
            end else if (prec_ff == '0) begin
               prec_in     = NUM_BITS'(dval);
               prec_run_in = 1'b1;
            end
         end else if (s1_char_ff == CH_DOT) begin
            dot_in = 1'b1;
         end else if (s1_char_ff == CH_H) begin
            len_in = (len_ff == LEN_H) ? LEN_HH : LEN_H;
         end else if (s1_char_ff == CH_LOW_L) begin
            len_in = (len_ff == LEN_L) ? LEN_LL : LEN_L;
         end else if (s1_char_ff == CH_UP_L) begin
            len_in = LEN_BIG_L;
         end else if ((s1_char_ff == CH_PCT) || conv) begin
            result.valid = 1'b1;
            if (conv) begin
               result.data.kind          = KIND_SPEC;
               result.data.flags         = flags_ff;
               result.data.min_width     = FIELD_W'(width_ff);
               result.data.has_precision = dot_ff;
               result.data.precision     = FIELD_W'(prec_ff);
               result.data.length_mod    = len_ff;
            end
            in_spec_in   = 1'b0;
            flags_in     = '0;
            width_in     = '0;
            width_run_in = 1'b0;
            dot_in       = 1'b0;
            prec_in      = '0;
            prec_run_in  = 1'b0;
            len_in       = LEN_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         in_spec_ff   <= 1'b0;
         flags_ff     <= '0;
         width_ff     <= '0;
         width_run_ff <= 1'b0;
         dot_ff       <= 1'b0;
         prec_ff      <= '0;
         prec_run_ff  <= 1'b0;
         len_ff       <= LEN_NONE;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (fire) begin
            in_spec_ff   <= in_spec_in;
            flags_ff     <= flags_in;
            width_ff     <= width_in;
            width_run_ff <= width_run_in;
            dot_ff       <= dot_in;
            prec_ff      <= prec_in;
            prec_run_ff  <= prec_run_in;
            len_ff       <= len_in;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fst_outreg.sv -----
`default_nettype none

module fst_outreg
   import fst_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       load,
   input  wire result_type result,
   output logic            advance,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output rsp_type         rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   assign advance   = !valid_ff || rsp_ready;
   assign valid_in  = load ? result.valid : (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.valid) begin
         data_ff <= result.data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/format_spec_tokenizer.sv -----
// Path: a word accepted on req_ passes the input register, then is decoded into
//    the result register, which drives rsp_.
// Throughput: one character word per cycle unless rsp_ stalls; the specifier
//    state loop closes in the single decode stage.
// Reset: synchronous, active high; clears the open specifier and all pending words.
`default_nettype none

module format_spec_tokenizer
   import fst_pkg::*;
#(
   parameter int NUM_BITS = NUM_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [CHAR_W-1:0]  req_tdata,   // [7:0] char_in
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // [7:0] char_out, [8] flag_plus, [9] flag_minus, [10] flag_alt, [11] flag_zero,
   // [12] flag_space, [28:13] min_width, [29] has_precision, [45:30] precision,
   // [48:46] length_mod, [55:49] zero
   output logic [TDATA_W-1:0]      rsp_tdata,
   output logic                    rsp_tuser    // [0] kind
);

   logic       advance;
   logic       fire;
   result_type result;
   rsp_type    rsp_data;

   fst_core #(
      .NUM_BITS (NUM_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .fire       (fire),
      .result     (result)
   );

   fst_outreg u_outreg (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (result),
      .advance   (advance),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {7'd0,
                       rsp_data.length_mod,
                       rsp_data.precision,
                       rsp_data.has_precision,
                       rsp_data.min_width,
                       rsp_data.flags,
                       rsp_data.char_out};

endmodule

`default_nettype wire

// ----- rtl/fst_checker.sv -----
`default_nettype none

module fst_checker
   import fst_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_tvalid,
   input wire logic               rsp_tready,
   input wire logic [TDATA_W-1:0] rsp_tdata,
   input wire logic               rsp_tuser
);

   logic [CHAR_W-1:0] out_char;

   assign out_char = rsp_tdata[CHAR_W-1:0];

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp word valid after reset");

   a_literal_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_LITERAL) |-> rsp_tdata[TDATA_W-1:CHAR_W] == '0)
      else $error("literal word carries specifier fields");

   a_spec_letter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SPEC) |->
         (out_char == CH_C) || (out_char == CH_D) || (out_char == CH_F) ||
         (out_char == CH_I) || (out_char == CH_S) || (out_char == CH_O) ||
         (out_char == CH_P) || (out_char == CH_U) || (out_char == CH_X) ||
         (out_char == CH_UP_X))
      else $error("specifier word without conversion letter");

   a_no_nul_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_char != CH_NUL) && (rsp_tdata[48:46] <= LEN_BIG_L))
      else $error("bad rsp word contents");

endmodule

bind format_spec_tokenizer fst_checker u_fst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
